// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the fade sequencer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Fire when cond is ever true outside reset.
`define RLFS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

// Fire when ante holds and cons does not, in the same cycle.
`define RLFS_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== hdl/rlfs_pkg.sv =====
// Shared constants, codes and helper functions of the fade sequencer.
package rlfs_pkg;

  localparam int CHANNELS   = 5;
  localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int VAL_W      = 8;
  localparam int TIME_W     = 24;
  localparam int CHAN_OUT_W = 3;
  localparam int DIV_STEPS  = 8;
  localparam int CNT_W      = $clog2(DIV_STEPS);

  localparam logic [1:0] PH_IDLE     = 2'd0;
  localparam logic [1:0] PH_FADING   = 2'd1;
  localparam logic [1:0] PH_COMPLETE = 2'd2;

  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_SET   = 2'd2;
  localparam logic [1:0] ACT_ABORT = 2'd3;

  localparam logic [1:0] LINK_OK   = 2'd0;
  localparam logic [1:0] LINK_BUSY = 2'd1;
  localparam logic [1:0] LINK_FAIL = 2'd2;

  localparam logic [7:0] MIN_INTERVAL_RST = 8'd10;
  localparam logic [7:0] SINCE_SAT        = 8'hFF;

  localparam logic [CH_W-1:0] SLOT_LAST = CH_W'(CHANNELS - 1);

  function automatic logic [CH_W-1:0] slot_channel(input logic [CH_W-1:0] slot);
    logic [CH_W-1:0] ch;
    if (slot == '0) begin
      ch = CH_W'(CHANNELS - 1);
    end else begin
      ch = slot - CH_W'(1);
    end
    return ch;
  endfunction

  localparam logic [CH_W-1:0] LAST_SEND_CH = slot_channel(SLOT_LAST);

  function automatic logic [VAL_W-1:0] chan_input(
    input logic [CH_W-1:0]  ch,
    input logic [VAL_W-1:0] bri,
    input logic [VAL_W-1:0] red,
    input logic [VAL_W-1:0] grn,
    input logic [VAL_W-1:0] blu,
    input logic [VAL_W-1:0] wht
  );
    logic [VAL_W-1:0] v;
    v = '0;
    if (32'(ch) == CHANNELS - 1) begin
      v = bri;
    end else if (32'(ch) == 0) begin
      v = red;
    end else if (32'(ch) == 1) begin
      v = grn;
    end else if (32'(ch) == 2) begin
      v = blu;
    end else if (32'(ch) == 3) begin
      v = wht;
    end
    return v;
  endfunction

endpackage

// ===== hdl/rlfs_interp.sv =====
// Shared interpolation unit: two multiply steps, then an eight-step restoring divide.
module rlfs_interp import rlfs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              go,
  input  logic [VAL_W-1:0]  s_val,
  input  logic [VAL_W-1:0]  t_val,
  input  logic [TIME_W-1:0] len,
  input  logic [TIME_W-1:0] el,
  output logic              done,
  output logic [VAL_W-1:0]  q
);

  localparam logic [1:0] I_IDLE = 2'd0;
  localparam logic [1:0] I_MB   = 2'd1;
  localparam logic [1:0] I_DIV  = 2'd2;

  localparam int PROD_W = VAL_W + TIME_W;
  localparam int REM_W  = PROD_W + 2;

  logic [1:0]        ist_r;
  logic [PROD_W-1:0] acc_r;
  logic [REM_W-1:0]  rem_r;
  logic [PROD_W-1:0] dsh_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [VAL_W-1:0]  q_r;
  logic              done_r;

  logic [VAL_W-1:0]  mul_a;
  logic [TIME_W-1:0] mul_b;
  logic [PROD_W-1:0] prod;
  logic [PROD_W:0]   sum;
  logic [REM_W-1:0]  rem_nxt;
  logic              ge;

  always_comb begin
    if (ist_r == I_IDLE) begin
      mul_a = s_val;
      mul_b = len - el;
    end else begin
      mul_a = t_val;
      mul_b = el;
    end
  end

  assign prod    = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign sum     = {1'b0, acc_r} + {1'b0, prod};
  assign rem_nxt = {sum, 1'b0} + REM_W'(len);
  assign ge      = rem_r >= REM_W'(dsh_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ist_r  <= I_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (ist_r)
        I_IDLE: begin
          if (go) begin
            acc_r <= prod;
            ist_r <= I_MB;
          end
        end
        I_MB: begin
          rem_r <= rem_nxt;
          dsh_r <= {len, 8'd0};
          cnt_r <= CNT_W'(DIV_STEPS - 1);
          ist_r <= I_DIV;
        end
        I_DIV: begin
          if (ge) begin
            rem_r <= rem_r - REM_W'(dsh_r);
          end
          q_r   <= {q_r[VAL_W-2:0], ge};
          dsh_r <= dsh_r >> 1;
          cnt_r <= cnt_r - CNT_W'(1);
          if (cnt_r == '0) begin
            done_r <= 1'b1;
            ist_r  <= I_IDLE;
          end
        end
        default: begin
          ist_r <= I_IDLE;
        end
      endcase
    end
  end

  assign done = done_r;
  assign q    = q_r;

endmodule

// ===== hdl/rgbw_linear_fade_sequencer.sv =====
// Top level of the RGBW linear fade sequencer.
// A start, set-current or abort item, and a tick outside the fading phase, yields one
// empty beat. A fading tick walks the five channels through one shared interpolation
// unit (multiply twice, then divide one quotient bit a cycle), and skips the unit for
// each channel once the fade has reached its end; the input stalls meanwhile, and
// longer while the result side stalls. Sends leave in the order brightness, red,
// green, blue, white.
`include "assert_macros.svh"

module rgbw_linear_fade_sequencer import rlfs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_action,
  input  logic [VAL_W-1:0]      in_brightness_in,
  input  logic [VAL_W-1:0]      in_red_in,
  input  logic [VAL_W-1:0]      in_green_in,
  input  logic [VAL_W-1:0]      in_blue_in,
  input  logic [VAL_W-1:0]      in_white_in,
  input  logic [TIME_W-1:0]     in_fade_time_ms,
  input  logic [1:0]            in_link_status,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_has_send,
  output logic [CHAN_OUT_W-1:0] out_channel,
  output logic [VAL_W-1:0]      out_channel_value,
  output logic [1:0]            out_fade_status,
  output logic                  out_last,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [7:0]            cfg_min_send_interval_ms
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CALC   = 3'd1;
  localparam logic [2:0] S_WAIT   = 3'd2;
  localparam logic [2:0] S_WB     = 3'd3;
  localparam logic [2:0] S_DECIDE = 3'd4;
  localparam logic [2:0] S_EMIT   = 3'd5;
  localparam logic [2:0] S_RESP   = 3'd6;

  logic [2:0]        state_r;
  logic [7:0]        min_r;
  logic [1:0]        phase_r;
  logic [VAL_W-1:0]  start_r   [CHANNELS];
  logic [VAL_W-1:0]  target_r  [CHANNELS];
  logic [VAL_W-1:0]  current_r [CHANNELS];
  logic [TIME_W-1:0] len_r;
  logic [TIME_W-1:0] elapsed_r;
  logic [7:0]        since_r;
  logic [CH_W-1:0]   slot_r;
  logic              pending_r;
  logic [CH_W-1:0]   idx_r;
  logic [1:0]        link_r;
  logic              at_end_r;
  logic              changed_r;
  logic              all_at_r;
  logic              fix_r;

  logic                  out_valid_r;
  logic                  out_has_send_r;
  logic [CHAN_OUT_W-1:0] out_channel_r;
  logic [VAL_W-1:0]      out_value_r;
  logic [1:0]            out_status_r;
  logic                  out_last_r;

  logic              out_free;
  logic [TIME_W-1:0] el_inc;
  logic [7:0]        since_inc;
  logic              iu_go;
  logic              iu_done;
  logic [VAL_W-1:0]  iu_q;
  logic [VAL_W-1:0]  wb_val;
  logic              burst_cond;
  logic              send_go;
  logic              burst_done;
  logic              pend_fin;
  logic              slot_zero_fin;
  logic              end_hit;
  logic              fix;
  logic [1:0]        ph_fin;

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;

  assign el_inc    = (elapsed_r < len_r) ? elapsed_r + TIME_W'(1) : elapsed_r;
  assign since_inc = (since_r == SINCE_SAT) ? since_r : since_r + 8'd1;

  assign iu_go  = (state_r == S_CALC) && !at_end_r;
  assign wb_val = at_end_r ? target_r[idx_r] : iu_q;

  assign burst_cond    = (changed_r || pending_r || (at_end_r && slot_r != '0)) &&
                         (since_r >= min_r);
  assign send_go       = burst_cond && (link_r == LINK_OK);
  assign burst_done    = burst_cond && (link_r != LINK_BUSY);
  assign pend_fin      = burst_done ? 1'b0 : pending_r;
  assign slot_zero_fin = burst_done || (slot_r == '0);
  assign end_hit       = at_end_r && !pend_fin && slot_zero_fin;
  assign fix           = end_hit && !all_at_r;
  assign ph_fin        = (end_hit && all_at_r) ? PH_COMPLETE : phase_r;

  rlfs_interp u_interp (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (iu_go),
    .s_val (start_r[idx_r]),
    .t_val (target_r[idx_r]),
    .len   (len_r),
    .el    (elapsed_r),
    .done  (iu_done),
    .q     (iu_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      min_r       <= MIN_INTERVAL_RST;
      phase_r     <= PH_IDLE;
      len_r       <= '0;
      elapsed_r   <= '0;
      since_r     <= SINCE_SAT;
      slot_r      <= '0;
      pending_r   <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        start_r[i]   <= '0;
        target_r[i]  <= '0;
        current_r[i] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        min_r <= cfg_min_send_interval_ms;
      end
      if (out_free) begin
        out_valid_r <= (state_r == S_EMIT) || (state_r == S_RESP);
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            link_r <= in_link_status;
            case (in_action)
              ACT_TICK: begin
                since_r <= since_inc;
                if (phase_r == PH_COMPLETE) begin
                  phase_r <= PH_IDLE;
                  state_r <= S_RESP;
                end else if (phase_r == PH_FADING) begin
                  elapsed_r <= el_inc;
                  at_end_r  <= (len_r == '0) || (el_inc >= len_r);
                  idx_r     <= '0;
                  changed_r <= 1'b0;
                  all_at_r  <= 1'b1;
                  state_r   <= S_CALC;
                end else begin
                  state_r <= S_RESP;
                end
              end
              ACT_START: begin
                len_r     <= in_fade_time_ms;
                elapsed_r <= '0;
                for (int i = 0; i < CHANNELS; i++) begin
                  start_r[i]  <= current_r[i];
                  target_r[i] <= chan_input(CH_W'(i), in_brightness_in, in_red_in,
                                            in_green_in, in_blue_in, in_white_in);
                  if (in_fade_time_ms == '0) begin
                    current_r[i] <= chan_input(CH_W'(i), in_brightness_in, in_red_in,
                                               in_green_in, in_blue_in, in_white_in);
                  end
                end
                phase_r   <= PH_FADING;
                pending_r <= 1'b1;
                slot_r    <= '0;
                state_r   <= S_RESP;
              end
              ACT_SET: begin
                for (int i = 0; i < CHANNELS; i++) begin
                  current_r[i] <= chan_input(CH_W'(i), in_brightness_in, in_red_in,
                                             in_green_in, in_blue_in, in_white_in);
                end
                state_r <= S_RESP;
              end
              default: begin
                phase_r   <= PH_IDLE;
                pending_r <= 1'b0;
                state_r   <= S_RESP;
              end
            endcase
          end
        end
        S_CALC: begin
          state_r <= at_end_r ? S_WB : S_WAIT;
        end
        S_WAIT: begin
          if (iu_done) begin
            state_r <= S_WB;
          end
        end
        S_WB: begin
          current_r[idx_r] <= wb_val;
          changed_r        <= changed_r | (wb_val != current_r[idx_r]);
          all_at_r         <= all_at_r & (wb_val == target_r[idx_r]);
          if (idx_r == SLOT_LAST) begin
            state_r <= S_DECIDE;
          end else begin
            idx_r   <= idx_r + CH_W'(1);
            state_r <= S_CALC;
          end
        end
        S_DECIDE: begin
          phase_r <= ph_fin;
          if (send_go) begin
            since_r <= '0;
            fix_r   <= fix;
            idx_r   <= slot_channel(slot_r);
            state_r <= S_EMIT;
          end else begin
            if (burst_done) begin
              slot_r <= '0;
            end
            if (fix) begin
              for (int i = 0; i < CHANNELS; i++) begin
                current_r[i] <= target_r[i];
              end
              pending_r <= 1'b1;
            end else if (burst_done) begin
              pending_r <= 1'b0;
            end
            state_r <= S_RESP;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_has_send_r <= 1'b1;
            out_channel_r  <= CHAN_OUT_W'(idx_r);
            out_value_r    <= current_r[idx_r];
            out_status_r   <= phase_r;
            out_last_r     <= (slot_r == SLOT_LAST);
            if (slot_r == SLOT_LAST) begin
              slot_r    <= '0;
              pending_r <= fix_r;
              if (fix_r) begin
                for (int i = 0; i < CHANNELS; i++) begin
                  current_r[i] <= target_r[i];
                end
              end
              state_r <= S_IDLE;
            end else begin
              slot_r <= slot_r + CH_W'(1);
              idx_r  <= slot_r;
            end
          end
        end
        S_RESP: begin
          if (out_free) begin
            out_has_send_r <= 1'b0;
            out_channel_r  <= '0;
            out_value_r    <= '0;
            out_status_r   <= phase_r;
            out_last_r     <= 1'b1;
            state_r        <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_has_send      = out_has_send_r;
  assign out_channel       = out_channel_r;
  assign out_channel_value = out_value_r;
  assign out_fade_status   = out_status_r;
  assign out_last          = out_last_r;

  `RLFS_ASSERT_NEVER(a_slot_range, slot_r > SLOT_LAST, "burst slot beyond last channel")
  `RLFS_ASSERT_IMPLIES(a_emit_phase, state_r == S_EMIT, phase_r == PH_FADING || phase_r == PH_COMPLETE, "send beat outside a fade")
  `RLFS_ASSERT_IMPLIES(a_last_send_ch, out_valid_r && out_has_send_r && out_last_r, out_channel_r == CHAN_OUT_W'(LAST_SEND_CH), "final send beat on wrong channel")
  `RLFS_ASSERT_IMPLIES(a_done_wait, iu_done, state_r == S_WAIT, "interpolation result with nobody waiting")

endmodule
